@@ design/crhp_pkg.sv @@
`default_nettype none

package crhp_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int FIELD_BITS         = 32;
    localparam int PREFIX_LEN         = 6;

    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // characters of the "bytes " prefix by position
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/content_range_header_parser.sv @@
`default_nettype none
// the result appears on the master side in the cycle after the transfer of the final character
// throughput: one character per cycle while the master side takes results
// the input side stalls only while a result is held and not taken
// i_rst_n is synchronous, active low: parser returns to prefix position zero
// with cleared accumulators, and no result is pending
module content_range_header_parser
    import crhp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [7:0]              i_s_axis_tdata,   // char_byte
    input  wire logic                    i_s_axis_tlast,   // final_char
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    output logic [3*FIELD_BITS-1:0]      o_m_axis_tdata,   // first_byte, last_byte, object_length
    output logic                         o_m_axis_tuser    // range_ok
);

    localparam int EXT_W = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    typedef enum logic [3:0] {
        PH_P0, PH_P1, PH_P2, PH_P3, PH_P4, PH_P5,
        PH_START, PH_LAST, PH_TOTAL
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [VALUE_BITS-1:0]   r_start, n_start;
    logic [VALUE_BITS-1:0]   r_end, n_end;
    logic [VALUE_BITS-1:0]   r_total, n_total;
    logic                    r_seen, n_seen;
    logic                    r_err, n_err;

    logic                    r_out_valid;
    logic                    r_out_ok, n_ok;
    logic [FIELD_BITS-1:0]   r_first, r_last, r_length;

    logic                    in_xfer;
    logic                    is_digit;
    logic [VALUE_BITS-1:0]   acc;
    logic [VALUE_BITS+3:0]   acc_wide;
    logic [VALUE_BITS+3:0]   prod;
    logic                    ovf;
    logic [EXT_W-1:0]        ext_start, ext_end, ext_total;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign is_digit        = (i_s_axis_tdata >= CH_ZERO) && (i_s_axis_tdata <= CH_NINE);

    always_comb begin
        case (r_phase)
            PH_START: acc = r_start;
            PH_LAST:  acc = r_end;
            default:  acc = r_total;
        endcase
    end

    // acc * 10 + digit, overflow when the top bits are set
    assign acc_wide = {4'b0000, acc};
    assign prod     = (acc_wide << 3) + (acc_wide << 1)
                    + {{VALUE_BITS{1'b0}}, i_s_axis_tdata[3:0]};
    assign ovf      = |prod[VALUE_BITS+3:VALUE_BITS];

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_end   = r_end;
        n_total = r_total;
        n_seen  = r_seen;
        n_err   = r_err;
        if (!r_err) begin
            if (r_phase < PH_START) begin
                if (i_s_axis_tdata == prefix_char(r_phase[2:0])) begin
                    n_phase = t_phase'(r_phase + 4'd1);
                end else begin
                    n_err = 1'b1;
                end
            end else if (is_digit) begin
                if (ovf) begin
                    n_err = 1'b1;
                end else begin
                    n_seen = 1'b1;
                    case (r_phase)
                        PH_START: n_start = prod[VALUE_BITS-1:0];
                        PH_LAST:  n_end   = prod[VALUE_BITS-1:0];
                        default:  n_total = prod[VALUE_BITS-1:0];
                    endcase
                end
            end else if (r_phase == PH_START && i_s_axis_tdata == CH_DASH && r_seen) begin
                n_phase = PH_LAST;
                n_seen  = 1'b0;
            end else if (r_phase == PH_LAST && i_s_axis_tdata == CH_SLASH && r_seen) begin
                n_phase = PH_TOTAL;
                n_seen  = 1'b0;
            end else begin
                n_err = 1'b1;
            end
        end
    end

    assign n_ok = !n_err && (n_phase == PH_TOTAL) && n_seen
               && (n_end >= n_start) && (n_total != '0) && (n_end < n_total);

    assign ext_start = EXT_W'(n_start);
    assign ext_end   = EXT_W'(n_end);
    assign ext_total = EXT_W'(n_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_P0;
            r_start     <= '0;
            r_end       <= '0;
            r_total     <= '0;
            r_seen      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_ok    <= 1'b0;
            r_first     <= '0;
            r_last      <= '0;
            r_length    <= '0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                if (i_s_axis_tlast) begin
                    r_phase     <= PH_P0;
                    r_start     <= '0;
                    r_end       <= '0;
                    r_total     <= '0;
                    r_seen      <= 1'b0;
                    r_err       <= 1'b0;
                    r_out_valid <= 1'b1;
                    // result payload, zero fields when the range is rejected
                    r_out_ok    <= n_ok;
                    r_first     <= n_ok ? ext_start[FIELD_BITS-1:0] : '0;
                    r_last      <= n_ok ? ext_end[FIELD_BITS-1:0]   : '0;
                    r_length    <= n_ok ? ext_total[FIELD_BITS-1:0] : '0;
                end else begin
                    r_phase <= n_phase;
                    r_start <= n_start;
                    r_end   <= n_end;
                    r_total <= n_total;
                    r_seen  <= n_seen;
                    r_err   <= n_err;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tdata  = {r_length, r_last, r_first};

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_s_axis_tlast) |=> r_out_valid)
        else $error("final character transfer produced no result");

    a_final_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_s_axis_tlast) |=> (r_phase == PH_P0 && !r_err && !r_seen))
        else $error("parser state not cleared after final character");

    a_reject_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_first == '0 && r_last == '0 && r_length == '0))
        else $error("rejected range carries nonzero fields");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result is stalled");

endmodule

`default_nettype wire

@@ tb/sv/tb_content_range_header_parser.sv @@
`default_nettype none

module tb_content_range_header_parser;
    import crhp_pkg::*;

    localparam int          VALUE_BITS  = VALUE_BITS_DEFAULT;
    localparam logic [63:0] VALUE_MAX   = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [3:0]  PH_START    = 4'd6;
    localparam logic [3:0]  PH_LAST     = 4'd7;
    localparam logic [3:0]  PH_TOTAL    = 4'd8;
    localparam int          CHAR_TARGET = 1850;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 10;

    typedef struct packed {
        logic                  ok;
        logic [FIELD_BITS-1:0] first;
        logic [FIELD_BITS-1:0] last;
        logic [FIELD_BITS-1:0] total;
    } t_range_result;

    class t_range_scoreboard;
        logic [3:0]    phase;
        logic [63:0]   start_acc;
        logic [63:0]   end_acc;
        logic [63:0]   total_acc;
        bit            have_digit;
        bit            bad;
        string         prefix_text;
        t_range_result pending_ranges[$];
        int            errors;

        function new();
            prefix_text = "bytes ";
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = 4'd0;
            start_acc = 64'd0;
            end_acc = 64'd0;
            total_acc = 64'd0;
            have_digit = 1'b0;
            bad = 1'b0;
        endfunction

        // one decimal digit into an accumulator, overflow is sticky error
        function logic [63:0] accumulate(input logic [63:0] acc, input logic [63:0] d);
            if (acc > (VALUE_MAX - d) / 64'd10) begin
                bad = 1'b1;
                return acc;
            end
            have_digit = 1'b1;
            return acc * 64'd10 + d;
        endfunction

        function void note_char(input logic [7:0] c, input logic fin);
            logic          ok;
            logic [63:0]   d;
            t_range_result r;
            d = {56'd0, c - CH_ZERO} & 64'hF;
            if (!bad) begin
                if (phase < PREFIX_LEN) begin
                    if (c == prefix_text[phase]) phase = phase + 4'd1;
                    else bad = 1'b1;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    case (phase)
                        PH_START: start_acc = accumulate(start_acc, d);
                        PH_LAST:  end_acc = accumulate(end_acc, d);
                        default:  total_acc = accumulate(total_acc, d);
                    endcase
                end else if (phase == PH_START && c == CH_DASH && have_digit) begin
                    phase = PH_LAST;
                    have_digit = 1'b0;
                end else if (phase == PH_LAST && c == CH_SLASH && have_digit) begin
                    phase = PH_TOTAL;
                    have_digit = 1'b0;
                end else begin
                    bad = 1'b1;
                end
            end
            if (fin) begin
                ok = !bad && phase == PH_TOTAL && have_digit && end_acc >= start_acc &&
                     total_acc != 64'd0 && end_acc < total_acc;
                r.ok = ok;
                r.first = ok ? start_acc[FIELD_BITS-1:0] : '0;
                r.last = ok ? end_acc[FIELD_BITS-1:0] : '0;
                r.total = ok ? total_acc[FIELD_BITS-1:0] : '0;
                pending_ranges.push_back(r);
                clear();
            end
        endfunction

        function void check_result(input logic ok, input logic [3*FIELD_BITS-1:0] data);
            t_range_result e;
            if (pending_ranges.size() == 0) begin
                $display("%0t: result with nothing expected: ok=%0d data=%h", $time, ok, data);
                errors++;
                return;
            end
            e = pending_ranges.pop_front();
            if (ok !== e.ok) begin
                $display("%0t: range_ok expected %0d actual %0d", $time, e.ok, ok);
                errors++;
            end
            if (data[FIELD_BITS-1:0] !== e.first) begin
                $display("%0t: first_byte expected %0d actual %0d", $time, e.first,
                         data[FIELD_BITS-1:0]);
                errors++;
            end
            if (data[2*FIELD_BITS-1:FIELD_BITS] !== e.last) begin
                $display("%0t: last_byte expected %0d actual %0d", $time, e.last,
                         data[2*FIELD_BITS-1:FIELD_BITS]);
                errors++;
            end
            if (data[3*FIELD_BITS-1:2*FIELD_BITS] !== e.total) begin
                $display("%0t: object_length expected %0d actual %0d", $time, e.total,
                         data[3*FIELD_BITS-1:2*FIELD_BITS]);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [7:0]              i_s_axis_tdata;   // char_byte
    logic                    i_s_axis_tlast;   // final_char
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [3*FIELD_BITS-1:0] o_m_axis_tdata;   // first_byte, last_byte, object_length
    logic                    o_m_axis_tuser;   // range_ok

    t_range_scoreboard sb;
    logic [7:0]        value_chars[$];
    int                sent_chars;
    int                idle_cycles;
    bit                s_calm;
    bit                m_calm;

    content_range_header_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_content_range_header_parser: done, errors");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if ($urandom_range(0, 39) == 0) s_calm = !s_calm;
        gap = s_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= c;
        i_s_axis_tlast <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_char(c, fin);
        sent_chars++;
        @(negedge i_clk);
    endtask

    task automatic take_results();
        int gap;
        forever begin
            if ($urandom_range(0, 39) == 0) m_calm = !m_calm;
            gap = m_calm ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
            @(negedge i_clk);
        end
    endtask

    task automatic send_value();
        int n;
        n = value_chars.size();
        for (int i = 0; i < n; i++) send_char(value_chars[i], i == n - 1);
        value_chars.delete();
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) value_chars.push_back(s[i]);
    endtask

    task automatic append_number(input logic [63:0] v, input int zeros);
        logic [7:0] digits[$];
        logic [63:0] rest;
        rest = v;
        repeat (zeros) value_chars.push_back(CH_ZERO);
        if (rest == 64'd0) digits.push_front(CH_ZERO);
        while (rest != 64'd0) begin
            digits.push_front(CH_ZERO + 8'(rest % 64'd10));
            rest = rest / 64'd10;
        end
        foreach (digits[i]) value_chars.push_back(digits[i]);
    endtask

    function automatic logic [63:0] pick_number();
        case ($urandom_range(0, 6))
            0:       return 64'($urandom_range(0, 9));
            1:       return 64'($urandom_range(0, 99999));
            2:       return 64'($urandom);
            3:       return VALUE_MAX - 64'($urandom_range(0, 3));
            4:       return VALUE_MAX + 64'd1 + 64'($urandom_range(0, 3));
            5:       return {$urandom, $urandom};
            default: return 64'($urandom_range(0, 2));
        endcase
    endfunction

    // "bytes S-L/T" with random content, some fields left empty now and then
    task automatic build_range(input bit allow_empty);
        logic [63:0] s, l, t;
        case ($urandom_range(0, 3))
            0: begin
                t = VALUE_MAX - 64'($urandom_range(0, 2));
                l = t - 64'($urandom_range(0, 2));
                s = l - 64'($urandom_range(0, 5));
            end
            1: begin
                s = pick_number();
                l = pick_number();
                t = pick_number();
            end
            default: begin
                s = pick_number();
                l = s + 64'($urandom_range(0, 1000));
                t = l + 64'($urandom_range(0, 1000)) + ($urandom_range(0, 4) == 0 ? 0 : 1);
            end
        endcase
        append_text("bytes ");
        if (!(allow_empty && $urandom_range(0, 2) == 0))
            append_number(s, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
        value_chars.push_back(CH_DASH);
        if (!(allow_empty && $urandom_range(0, 2) == 0))
            append_number(l, $urandom_range(0, 5) == 0 ? 1 : 0);
        value_chars.push_back(CH_SLASH);
        if (!(allow_empty && $urandom_range(0, 2) == 0))
            append_number(t, $urandom_range(0, 5) == 0 ? 1 : 0);
    endtask

    task automatic corrupt_value();
        int pos;
        pos = $urandom_range(0, value_chars.size() - 1);
        case ($urandom_range(0, 4))
            0: value_chars[pos] = 8'($urandom_range(0, 255));
            1: if (value_chars.size() > 1) value_chars.delete(pos);
            2: value_chars.insert(pos, 8'($urandom_range(0, 255)));
            3: while (value_chars.size() > pos + 1) value_chars.delete(value_chars.size() - 1);
            default: value_chars.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        int kind;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 8'd0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b0;
        sent_chars = 0;
        idle_cycles = 0;
        s_calm = 1'b0;
        m_calm = 1'b0;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none

        // smallest valid range, empty start, lone nul and 0xff, end inside the prefix
        append_text("bytes 0-0/1");
        send_value();
        append_text("bytes -");
        send_value();
        value_chars.push_back(8'h00);
        send_value();
        value_chars.push_back(8'hFF);
        send_value();
        append_text("by");
        send_value();

        while (sent_chars < CHAR_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                build_range(1'b0);
                if ($urandom_range(0, 3) == 0) corrupt_value();
            end else if (kind == 7) begin
                build_range(1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) value_chars.push_back(8'($urandom_range(0, 255)));
            end
            send_value();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_content_range_header_parser: done, clean");
        else
            $display("tb_content_range_header_parser: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
